/* rtl/guillotine_rect_packer_macros.svh */
// assertion macros shared by the packer modules
`ifndef GUILLOTINE_RECT_PACKER_MACROS_SVH
`define GUILLOTINE_RECT_PACKER_MACROS_SVH

// condition holds in the same cycle as the trigger
`define GRP_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// condition holds in the cycle after the trigger
`define GRP_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/grp_pkg.sv */
// shared types and constants of the guillotine rectangle packer
`timescale 1ns / 1ps
package grp_pkg;

	localparam int IMG_BITS     = 13;
	localparam int POS_BITS     = 12;
	localparam int PAD_BITS     = 8;
	localparam int REG_BITS     = 13;
	localparam int CFG_IDX_BITS = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_ATLAS_W = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ATLAS_H = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SKIP    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TEX_W   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TEX_H   = 3'd4;

	// configuration reset values
	localparam logic [REG_BITS-1:0] ATLAS_W_RST = 13'd2048;
	localparam logic [REG_BITS-1:0] ATLAS_H_RST = 13'd2048;
	localparam logic [REG_BITS-1:0] SKIP_RST    = 13'd3;
	localparam logic [REG_BITS-1:0] TEX_W_RST   = 13'd2048;
	localparam logic [REG_BITS-1:0] TEX_H_RST   = 13'd2048;

	typedef enum logic [1:0] {
		OPER_PLACE   = 2'd0,
		OPER_RESTART = 2'd1,
		OPER_CLOSE   = 2'd2,
		OPER_NOP     = 2'd3
	} oper_t;

	// datapath commands issued by the controller
	typedef enum logic [4:0] {
		CMD_IDLE      = 5'd0,
		CMD_LOAD      = 5'd1,
		CMD_RESTART   = 5'd2,
		CMD_CLOSE     = 5'd3,
		CMD_SCAN_RD   = 5'd4,
		CMD_SCAN_TAKE = 5'd5,
		CMD_SCAN_NEXT = 5'd6,
		CMD_ERASE_RD  = 5'd7,
		CMD_ERASE_WR  = 5'd8,
		CMD_SPLIT     = 5'd9,
		CMD_INS_BEGIN = 5'd10,
		CMD_INS_DROP  = 5'd11,
		CMD_INS_RD    = 5'd12,
		CMD_INS_NEXT  = 5'd13,
		CMD_SHIFT_RD  = 5'd14,
		CMD_SHIFT_WR  = 5'd15,
		CMD_INS_WR    = 5'd16
	} dp_cmd_t;

	// datapath status seen by the controller
	typedef struct packed {
		logic scan_end;
		logic fit;
		logic erase_end;
		logic list_full;
		logic pend_none;
		logic key_less;
		logic shift_done;
	} dp_status_t;

endpackage

/* rtl/grp_datapath.sv */
// free list memory, item registers, splitter and union box of the packer
`timescale 1ns / 1ps
module grp_datapath #(
	parameter int FREE_SLOTS = 64,
	parameter int COORD_BITS = 13
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  grp_pkg::dp_cmd_t                   cmd,
	output grp_pkg::dp_status_t                status,
	input  logic [grp_pkg::IMG_BITS-1:0]       image_width,
	input  logic [grp_pkg::IMG_BITS-1:0]       image_height,
	input  logic [grp_pkg::PAD_BITS-1:0]       pad_x,
	input  logic [grp_pkg::PAD_BITS-1:0]       pad_y,
	input  logic                               has_texture,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [grp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [grp_pkg::REG_BITS-1:0]       cfg_data,
	output logic                               placed,
	output logic [grp_pkg::POS_BITS-1:0]       pos_x,
	output logic [grp_pkg::POS_BITS-1:0]       pos_y,
	output logic [grp_pkg::IMG_BITS-1:0]       bounds_left,
	output logic [grp_pkg::IMG_BITS-1:0]       bounds_top,
	output logic [grp_pkg::IMG_BITS-1:0]       bounds_right,
	output logic [grp_pkg::IMG_BITS-1:0]       bounds_bottom,
	output logic                               list_overflow
);
	import grp_pkg::*;

	`include "guillotine_rect_packer_macros.svh"

	localparam int CB = COORD_BITS;
	localparam int AW = $clog2(FREE_SLOTS);
	localparam int CW = $clog2(FREE_SLOTS + 1);
	localparam int EB = ((CB > IMG_BITS) ? CB : IMG_BITS) + 2;

	typedef struct packed {
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic [CB-1:0] w;
		logic [CB-1:0] h;
	} rect_t;

	function automatic logic [CB-1:0] short_side(input rect_t r);
		return (r.w < r.h) ? r.w : r.h;
	endfunction

	// configuration registers
	logic [REG_BITS-1:0] atlas_w_q, atlas_h_q, skip_q, tex_w_q, tex_h_q;

	// item registers
	logic [IMG_BITS-1:0] iw_q, ih_q;
	logic [PAD_BITS-1:0] px_q, py_q;
	logic [EB-1:0]       w_q, h_q;

	// list control and result registers
	logic [CW-1:0] idx_q, sh_q, cnt_q;
	logic [1:0]    pend_q;
	logic          ovf_q, placed_q;
	logic [CB-1:0] pos_x_q, pos_y_q;
	logic [CB-1:0] box_l_q, box_t_q, box_r_q, box_b_q;
	rect_t         rect_q, a_q, b_q, rd_q;

	rect_t mem [FREE_SLOTS];

	// combinational helpers
	logic [PAD_BITS-1:0] px_eff, py_eff;
	logic [EB-1:0]       w_in, h_in;
	logic [CB-1:0]       ox, oy, rt, bt;
	logic                box_live;
	logic [CB-1:0]       dsx, dsy;
	rect_t               a_new, b_new, cur, restart_rect;
	logic                keep_a, keep_b;
	logic [CW-1:0]       idx_inc, sh_dec;
	logic                rd_en, wr_en;
	logic [AW-1:0]       rd_addr, wr_addr;
	rect_t               wr_data;

	assign cfg_ready = 1'b1;

	// configuration write transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_w_q <= ATLAS_W_RST;
			atlas_h_q <= ATLAS_H_RST;
			skip_q    <= SKIP_RST;
			tex_w_q   <= TEX_W_RST;
			tex_h_q   <= TEX_H_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ATLAS_W: atlas_w_q <= cfg_data;
				CFG_ATLAS_H: atlas_h_q <= cfg_data;
				CFG_SKIP:    skip_q    <= cfg_data;
				CFG_TEX_W:   tex_w_q   <= cfg_data;
				CFG_TEX_H:   tex_h_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// pad rule and padded size
	always_comb begin
		px_eff = (has_texture && (image_width == tex_w_q)) ? '0 : pad_x;
		py_eff = (has_texture && (image_height == tex_h_q)) ? '0 : pad_y;
		w_in   = EB'(image_width) + EB'({px_eff, 1'b0});
		h_in   = EB'(image_height) + EB'({py_eff, 1'b0});
	end

	// placement position and union box candidate
	always_comb begin
		ox       = CB'(EB'(rd_q.x) + EB'(px_q));
		oy       = CB'(EB'(rd_q.y) + EB'(py_q));
		rt       = CB'(EB'(ox) + EB'(iw_q));
		bt       = CB'(EB'(oy) + EB'(ih_q));
		box_live = (box_r_q > box_l_q) && (box_b_q > box_t_q);
	end

	// guillotine split of the taken rectangle
	always_comb begin
		dsx   = rect_q.w - CB'(w_q);
		dsy   = rect_q.h - CB'(h_q);
		a_new = rect_q;
		b_new = rect_q;
		if (dsx > dsy) begin
			a_new.w = CB'(w_q);
		end else begin
			b_new.h = CB'(h_q);
		end
		b_new.w = dsx;
		a_new.h = dsy;
		a_new.y = CB'(EB'(rect_q.y) + h_q);
		b_new.x = CB'(EB'(rect_q.x) + w_q);
		keep_a  = EB'(short_side(a_new)) > EB'(skip_q);
		keep_b  = EB'(short_side(b_new)) > EB'(skip_q);
	end

	always_comb begin
		cur             = pend_q[0] ? a_q : b_q;
		idx_inc         = idx_q + CW'(1);
		sh_dec          = sh_q - CW'(1);
		restart_rect.x  = '0;
		restart_rect.y  = '0;
		restart_rect.w  = CB'(EB'(atlas_w_q));
		restart_rect.h  = CB'(EB'(atlas_h_q));
	end

	// memory port selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = rd_q;
		case (cmd)
			CMD_SCAN_RD, CMD_INS_RD: rd_en = 1'b1;
			CMD_ERASE_RD: begin
				rd_en   = 1'b1;
				rd_addr = idx_inc[AW-1:0];
			end
			CMD_SHIFT_RD: begin
				rd_en   = 1'b1;
				rd_addr = sh_dec[AW-1:0];
			end
			CMD_RESTART: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = restart_rect;
			end
			CMD_ERASE_WR: wr_en = 1'b1;
			CMD_SHIFT_WR: begin
				wr_en   = 1'b1;
				wr_addr = sh_q[AW-1:0];
			end
			CMD_INS_WR: begin
				wr_en   = 1'b1;
				wr_data = cur;
			end
			default: ;
		endcase
	end

	// free list memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// item, list and union box registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q     <= '0;
			ih_q     <= '0;
			px_q     <= '0;
			py_q     <= '0;
			w_q      <= '0;
			h_q      <= '0;
			rect_q   <= '0;
			a_q      <= '0;
			b_q      <= '0;
			idx_q    <= '0;
			sh_q     <= '0;
			cnt_q    <= '0;
			pend_q   <= '0;
			ovf_q    <= 1'b0;
			placed_q <= 1'b0;
			pos_x_q  <= '0;
			pos_y_q  <= '0;
			box_l_q  <= '0;
			box_t_q  <= '0;
			box_r_q  <= '0;
			box_b_q  <= '0;
		end else begin
			case (cmd)
				CMD_LOAD: begin
					iw_q     <= image_width;
					ih_q     <= image_height;
					px_q     <= px_eff;
					py_q     <= py_eff;
					w_q      <= w_in;
					h_q      <= h_in;
					placed_q <= 1'b0;
					ovf_q    <= 1'b0;
					pos_x_q  <= '0;
					pos_y_q  <= '0;
					idx_q    <= '0;
				end
				CMD_RESTART: begin
					cnt_q   <= CW'(1);
					box_l_q <= '0;
					box_t_q <= '0;
					box_r_q <= '0;
					box_b_q <= '0;
				end
				CMD_CLOSE: cnt_q <= '0;
				CMD_SCAN_TAKE: begin
					rect_q   <= rd_q;
					placed_q <= 1'b1;
					pos_x_q  <= ox;
					pos_y_q  <= oy;
					if (!box_live) begin
						box_l_q <= ox;
						box_t_q <= oy;
						box_r_q <= rt;
						box_b_q <= bt;
					end else begin
						if (ox < box_l_q) box_l_q <= ox;
						if (oy < box_t_q) box_t_q <= oy;
						if (rt > box_r_q) box_r_q <= rt;
						if (bt > box_b_q) box_b_q <= bt;
					end
				end
				CMD_SCAN_NEXT, CMD_ERASE_WR, CMD_INS_NEXT: idx_q <= idx_inc;
				CMD_SPLIT: begin
					cnt_q  <= cnt_q - CW'(1);
					a_q    <= a_new;
					b_q    <= b_new;
					pend_q <= {keep_b, keep_a};
				end
				CMD_INS_BEGIN: begin
					idx_q <= '0;
					sh_q  <= cnt_q;
				end
				CMD_INS_DROP: begin
					ovf_q  <= 1'b1;
					pend_q <= pend_q[0] ? {pend_q[1], 1'b0} : 2'b00;
				end
				CMD_SHIFT_WR: sh_q <= sh_dec;
				CMD_INS_WR: begin
					cnt_q  <= cnt_q + CW'(1);
					pend_q <= pend_q[0] ? {pend_q[1], 1'b0} : 2'b00;
				end
				default: ;
			endcase
		end
	end

	// status to the controller
	always_comb begin
		status.scan_end   = idx_q >= cnt_q;
		status.fit        = (EB'(rd_q.w) >= w_q) && (EB'(rd_q.h) >= h_q);
		status.erase_end  = idx_inc >= cnt_q;
		status.list_full  = cnt_q >= CW'(FREE_SLOTS);
		status.pend_none  = pend_q == 2'b00;
		status.key_less   = short_side(rd_q) < short_side(cur);
		status.shift_done = sh_q == idx_q;
	end

	// result fields
	assign placed        = placed_q;
	assign pos_x         = POS_BITS'(EB'(pos_x_q));
	assign pos_y         = POS_BITS'(EB'(pos_y_q));
	assign bounds_left   = IMG_BITS'(EB'(box_l_q));
	assign bounds_top    = IMG_BITS'(EB'(box_t_q));
	assign bounds_right  = IMG_BITS'(EB'(box_r_q));
	assign bounds_bottom = IMG_BITS'(EB'(box_b_q));
	assign list_overflow = ovf_q;

	`GRP_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CW'(FREE_SLOTS), "free count beyond capacity")
	`GRP_ASSERT_IMP(a_ins_room, cmd == CMD_INS_WR, cnt_q < CW'(FREE_SLOTS), "insert into full list")
	`GRP_ASSERT_IMP(a_erase_range, cmd == CMD_ERASE_WR, idx_inc < cnt_q, "erase move past list end")

endmodule

/* rtl/grp_ctrl.sv */
// sequencing state machine of the packer
`timescale 1ns / 1ps
module grp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            operation,
	output logic                  busy,
	output logic                  done,
	output grp_pkg::dp_cmd_t      cmd,
	input  grp_pkg::dp_status_t   status
);
	import grp_pkg::*;

	`include "guillotine_rect_packer_macros.svh"

	typedef enum logic [14:0] {
		S_IDLE      = 15'h0001,
		S_RESTART   = 15'h0002,
		S_CLOSE     = 15'h0004,
		S_SCAN_RD   = 15'h0008,
		S_SCAN_CHK  = 15'h0010,
		S_ERASE_RD  = 15'h0020,
		S_ERASE_WR  = 15'h0040,
		S_SPLIT     = 15'h0080,
		S_INS_BEGIN = 15'h0100,
		S_INS_RD    = 15'h0200,
		S_INS_CHK   = 15'h0400,
		S_SHIFT_RD  = 15'h0800,
		S_SHIFT_WR  = 15'h1000,
		S_INS_WR    = 15'h2000,
		S_FINISH    = 15'h4000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath command
	always_comb begin
		state_d = state_q;
		cmd     = CMD_IDLE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd = CMD_LOAD;
					unique case (oper_t'(operation))
						OPER_PLACE:   state_d = S_SCAN_RD;
						OPER_RESTART: state_d = S_RESTART;
						OPER_CLOSE:   state_d = S_CLOSE;
						default:      state_d = S_FINISH;
					endcase
				end
			end
			S_RESTART: begin
				cmd     = CMD_RESTART;
				state_d = S_FINISH;
			end
			S_CLOSE: begin
				cmd     = CMD_CLOSE;
				state_d = S_FINISH;
			end
			S_SCAN_RD: begin
				if (status.scan_end) begin
					state_d = S_FINISH;
				end else begin
					cmd     = CMD_SCAN_RD;
					state_d = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				if (status.fit) begin
					cmd     = CMD_SCAN_TAKE;
					state_d = S_ERASE_RD;
				end else begin
					cmd     = CMD_SCAN_NEXT;
					state_d = S_SCAN_RD;
				end
			end
			S_ERASE_RD: begin
				if (status.erase_end) begin
					state_d = S_SPLIT;
				end else begin
					cmd     = CMD_ERASE_RD;
					state_d = S_ERASE_WR;
				end
			end
			S_ERASE_WR: begin
				cmd     = CMD_ERASE_WR;
				state_d = S_ERASE_RD;
			end
			S_SPLIT: begin
				cmd     = CMD_SPLIT;
				state_d = S_INS_BEGIN;
			end
			S_INS_BEGIN: begin
				if (status.pend_none) begin
					state_d = S_FINISH;
				end else if (status.list_full) begin
					cmd = CMD_INS_DROP;
				end else begin
					cmd     = CMD_INS_BEGIN;
					state_d = S_INS_RD;
				end
			end
			S_INS_RD: begin
				if (status.scan_end) begin
					state_d = S_SHIFT_RD;
				end else begin
					cmd     = CMD_INS_RD;
					state_d = S_INS_CHK;
				end
			end
			S_INS_CHK: begin
				if (status.key_less) begin
					cmd     = CMD_INS_NEXT;
					state_d = S_INS_RD;
				end else begin
					state_d = S_SHIFT_RD;
				end
			end
			S_SHIFT_RD: begin
				if (status.shift_done) begin
					state_d = S_INS_WR;
				end else begin
					cmd     = CMD_SHIFT_RD;
					state_d = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				cmd     = CMD_SHIFT_WR;
				state_d = S_SHIFT_RD;
			end
			S_INS_WR: begin
				cmd     = CMD_INS_WR;
				state_d = S_INS_BEGIN;
			end
			S_FINISH: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_FINISH;

	`GRP_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transaction did not start")
	`GRP_ASSERT_NXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
	`GRP_ASSERT_IMP(a_done_busy, done, busy, "result strobe while idle")

endmodule

/* rtl/guillotine_rect_packer.sv */
// Guillotine rectangle packer: places padded images first-fit into a sorted free list.
// One item is taken at a time: start is accepted while busy is low, and busy stays high
// until the result transaction, which is shown for exactly one cycle with done high; the
// receiver cannot stall it. Restart and close items pass through their own state, a no-op
// item straight to the finish state. A placement walks the free list through a memory with
// registered reads: it scans for the first fit, moves later entries up to erase it, splits
// the taken rectangle and inserts each kept piece in sorted order, moving later entries
// down. Configuration writes are taken at any time (cfg_ready is always high) but must
// only be issued while busy is low.
`timescale 1ns / 1ps
module guillotine_rect_packer #(
	parameter int FREE_SLOTS = 64,
	parameter int COORD_BITS = 13
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       operation,
	input  logic [grp_pkg::IMG_BITS-1:0]     image_width,
	input  logic [grp_pkg::IMG_BITS-1:0]     image_height,
	input  logic [grp_pkg::PAD_BITS-1:0]     pad_x,
	input  logic [grp_pkg::PAD_BITS-1:0]     pad_y,
	input  logic                             has_texture,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [grp_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [grp_pkg::REG_BITS-1:0]     cfg_data,
	output logic                             done,
	output logic                             placed,
	output logic [grp_pkg::POS_BITS-1:0]     pos_x,
	output logic [grp_pkg::POS_BITS-1:0]     pos_y,
	output logic [grp_pkg::IMG_BITS-1:0]     bounds_left,
	output logic [grp_pkg::IMG_BITS-1:0]     bounds_top,
	output logic [grp_pkg::IMG_BITS-1:0]     bounds_right,
	output logic [grp_pkg::IMG_BITS-1:0]     bounds_bottom,
	output logic                             list_overflow
);
	import grp_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// controller
	grp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.busy      (busy),
		.done      (done),
		.cmd       (cmd),
		.status    (status)
	);

	// datapath
	grp_datapath #(
		.FREE_SLOTS (FREE_SLOTS),
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.image_width   (image_width),
		.image_height  (image_height),
		.pad_x         (pad_x),
		.pad_y         (pad_y),
		.has_texture   (has_texture),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.placed        (placed),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.bounds_left   (bounds_left),
		.bounds_top    (bounds_top),
		.bounds_right  (bounds_right),
		.bounds_bottom (bounds_bottom),
		.list_overflow (list_overflow)
	);

endmodule
